>>> hdl/arcc_pkg.sv
// Package for the archive record chain checker: result and error codes,
// header layout constants and the word types passed between the front and back.
`timescale 1ns / 1ps
package arcc_pkg;

   localparam int unsigned HEADER_BYTES = 31;
   localparam int unsigned NAME_BUFFER_BYTES = 12;
   localparam logic [7:0] VERSION_BYTE = 8'h10;
   localparam logic [7:0] METHOD_BINARY = 8'h00;
   localparam logic [7:0] METHOD_ASCII = 8'h01;
   localparam logic [7:0] METHOD_STORED = 8'hff;
   localparam logic [7:0] DICT_LOW = 8'd4;
   localparam logic [7:0] DICT_HIGH = 8'd6;
   localparam logic [7:0] PRINT_LOW = 8'h20;
   localparam logic [7:0] PRINT_HIGH = 8'h7e;
   localparam logic [31:0] PLAIN_LIMIT_RESET = 32'h1000_0000;

   typedef enum logic [1:0] {
      KIND_MEMBER = 2'd0,
      KIND_ACCEPT = 2'd1,
      KIND_REJECT = 2'd2
   } kind_type;

   typedef enum logic [3:0] {
      ERR_NONE      = 4'd0,
      ERR_SPAN      = 4'd1,
      ERR_COUNT     = 4'd2,
      ERR_MAGIC     = 4'd3,
      ERR_VERSION   = 4'd4,
      ERR_METHOD    = 4'd5,
      ERR_RECORD    = 4'd6,
      ERR_PLAIN     = 4'd7,
      ERR_NAME_LEN  = 4'd8,
      ERR_NAME_BYTE = 4'd9,
      ERR_STORED    = 4'd10,
      ERR_PAYLOAD   = 4'd11,
      ERR_MODE      = 4'd12,
      ERR_DICT      = 4'd13,
      ERR_TRUNC     = 4'd14
   } err_type;

   typedef enum logic [0:0] {
      PHASE_HEADER  = 1'b0,
      PHASE_PAYLOAD = 1'b1
   } phase_type;

   localparam int unsigned CSR_ARCHIVE_LENGTH = 0;
   localparam int unsigned CSR_PLAIN_LIMIT = 1;

   typedef struct packed {
      kind_type    kind;
      err_type     err;
      logic [16:0] index;
      logic [7:0]  method;
      logic [31:0] plain;
      logic [31:0] packed_sz;
      logic [31:0] crc;
      logic [3:0]  name_len;
      logic [47:0] offset;
   } result_type;

   function automatic logic [7:0] magic_byte(input logic [1:0] idx);
      logic [7:0] val;
      unique case (idx)
         2'd0: val = 8'h41;
         2'd1: val = 8'h47;
         2'd2: val = 8'h49;
         default: val = 8'h53;
      endcase
      return val;
   endfunction

endpackage

>>> hdl/archive_record_chain_checker_core.sv
// Top level of the archive record chain checker: configuration registers,
// byte parser front, result queue and output register. Depends on arcc_pkg.
//
// Use: write archive_length (index 0) and plain_size_limit (index 1) on the
// csr_ channel while idle, then stream the archive one word per cycle on
// req_ with req_start_of_archive set on the first byte. The parser checks a
// byte in the cycle it is taken and writes any result into the queue at the
// accepting edge; the output register loads it from the queue once the
// register is empty or not stalled, and rsp_valid is driven by that register.
// At most one result follows each byte: one per accepted member and a final
// verdict.
// Throughput is one byte per cycle while req_stall is low. req_stall is
// high only while the four-entry result queue is full, so a receiver stall
// holds the sender only once four results wait behind the output register.
// Reset (synchronous, active high) empties the queue, clears the parse
// state and restores the register reset values.
`timescale 1ns / 1ps
module archive_record_chain_checker_core #(
   parameter int unsigned MAX_MEMBERS = 100000
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [7:0]   req_data_byte,
   input  logic         req_start_of_archive,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [1:0]   rsp_result_kind,
   output logic [3:0]   rsp_error_code,
   output logic [16:0]  rsp_member_index,
   output logic [7:0]   rsp_method,
   output logic [31:0]  rsp_plain_size,
   output logic [31:0]  rsp_packed_size,
   output logic [31:0]  rsp_stored_crc,
   output logic [3:0]   rsp_name_length,
   output logic [47:0]  rsp_header_offset,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [0:0]   csr_index,
   input  logic [47:0]  csr_data
);
   import arcc_pkg::*;

   logic [47:0] alen_ff, alen_in;
   logic [31:0] limit_ff, limit_in;
   logic        take;
   logic        fr_valid;
   result_type  fr_word;
   logic        q_full, q_empty, q_pop;
   result_type  q_head;
   logic        out_valid_ff, out_valid_in;
   result_type  out_ff, out_in;

   assign csr_ready = 1'b1;
   always_comb begin
      alen_in = alen_ff;
      limit_in = limit_ff;
      if (csr_valid && csr_index == 1'(CSR_ARCHIVE_LENGTH)) alen_in = csr_data;
      if (csr_valid && csr_index == 1'(CSR_PLAIN_LIMIT)) limit_in = csr_data[31:0];
   end

   // Stall as soon as the queue cannot absorb the byte in flight.
   assign req_stall = q_full;
   assign take = req_valid && !req_stall;

   arcc_front #(.MAX_MEMBERS(MAX_MEMBERS)) u_front (
      .clock(clock), .reset(reset), .byte_valid(take), .byte_data(req_data_byte),
      .byte_start(req_start_of_archive), .archive_length(alen_ff),
      .plain_limit(limit_ff), .res_valid(fr_valid), .res_word(fr_word)
   );

   arcc_queue u_queue (
      .clock(clock), .reset(reset), .push(fr_valid), .push_word(fr_word),
      .full(q_full), .empty(q_empty), .pop(q_pop), .head_word(q_head)
   );

   assign q_pop = !q_empty && (!out_valid_ff || !rsp_stall);
   always_comb begin
      out_valid_in = out_valid_ff;
      out_in = out_ff;
      if (!out_valid_ff || !rsp_stall) begin
         out_valid_in = q_pop;
         out_in = q_head;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alen_ff <= '0;
         limit_ff <= PLAIN_LIMIT_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         alen_ff <= alen_in;
         limit_ff <= limit_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_result_kind = out_ff.kind;
   assign rsp_error_code = out_ff.err;
   assign rsp_member_index = out_ff.index;
   assign rsp_method = out_ff.method;
   assign rsp_plain_size = out_ff.plain;
   assign rsp_packed_size = out_ff.packed_sz;
   assign rsp_stored_crc = out_ff.crc;
   assign rsp_name_length = out_ff.name_len;
   assign rsp_header_offset = out_ff.offset;

`ifndef SYNTH
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !fr_valid) else $error("result queue overflow");
   a_reject_has_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_result_kind == KIND_REJECT) |-> rsp_error_code != ERR_NONE)
      else $error("reject without error code");
   a_member_no_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_result_kind != KIND_REJECT) |-> rsp_error_code == ERR_NONE)
      else $error("error code on accepted result");
`endif

endmodule

>>> hdl/arcc_front.sv
// Front part of the archive record chain checker: parses one byte per cycle
// while byte_valid is high, checks the header chain and emits at most one
// result word per byte. Depends on arcc_pkg.
`timescale 1ns / 1ps
module arcc_front #(
   parameter int unsigned MAX_MEMBERS = 100000
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  byte_valid,
   input  logic [7:0]            byte_data,
   input  logic                  byte_start,
   input  logic [47:0]           archive_length,
   input  logic [31:0]           plain_limit,
   output logic                  res_valid,
   output arcc_pkg::result_type  res_word
);
   import arcc_pkg::*;

   logic [47:0] pos_ff, pos_in;
   logic [47:0] rec_ff, rec_in;
   logic [4:0]  hidx_ff, hidx_in;
   phase_type   phase_ff, phase_in;
   logic [7:0]  meth_ff, meth_in;
   logic [31:0] crc_ff, crc_in;
   logic [31:0] plain_ff, plain_in;
   logic [31:0] recsz_ff, recsz_in;
   logic [3:0]  nlen_ff, nlen_in;
   logic [16:0] count_ff, count_in;
   logic        stop_ff, stop_in;
   // Remaining span from the current record start.
   logic [47:0] remain;
   logic [47:0] last_pos;
   logic [47:0] next_rec;
   logic [31:0] packed_sz;
   logic [31:0] recsz_full;
   logic [47:0] pay_off;

   // Effective parse state for this byte after a possible start.
   logic [47:0] p_pos, p_rec;
   logic [4:0]  p_hidx;
   phase_type   p_phase;
   logic [7:0]  p_meth;
   logic [31:0] p_crc, p_plain, p_recsz;
   logic [3:0]  p_nlen;
   logic [16:0] p_count;

   always_comb begin
      if (byte_start) begin
         p_pos = '0; p_rec = '0; p_hidx = '0; p_phase = PHASE_HEADER;
         p_meth = '0; p_crc = '0; p_plain = '0; p_recsz = '0; p_nlen = '0;
         p_count = '0;
      end else begin
         p_pos = pos_ff; p_rec = rec_ff; p_hidx = hidx_ff; p_phase = phase_ff;
         p_meth = meth_ff; p_crc = crc_ff; p_plain = plain_ff; p_recsz = recsz_ff;
         p_nlen = nlen_ff; p_count = count_ff;
      end
   end

   assign remain = (archive_length >= p_rec) ? (archive_length - p_rec) : '0;
   assign recsz_full = {byte_data, p_recsz[23:0]};
   assign packed_sz = p_recsz - 32'(HEADER_BYTES);
   assign last_pos = p_rec + {16'd0, p_recsz} - 48'd1;
   assign next_rec = p_pos + 48'd1;
   assign pay_off = p_pos - p_rec - 48'(HEADER_BYTES);

   always_comb begin
      logic       fail;
      err_type    err;
      logic       acc;
      logic       done;
      logic [4:0] h;
      fail = 1'b0; err = ERR_NONE; acc = 1'b0; done = 1'b0;
      h = p_hidx;
      pos_in = pos_ff; rec_in = rec_ff; hidx_in = hidx_ff; phase_in = phase_ff;
      meth_in = meth_ff; crc_in = crc_ff; plain_in = plain_ff; recsz_in = recsz_ff;
      nlen_in = nlen_ff; count_in = count_ff; stop_in = stop_ff;
      res_valid = 1'b0;
      res_word = '0;
      if (byte_valid && (byte_start || !stop_ff)) begin
         pos_in = p_pos + 48'd1;
         rec_in = p_rec; hidx_in = p_hidx; phase_in = p_phase;
         meth_in = p_meth; crc_in = p_crc; plain_in = p_plain; recsz_in = p_recsz;
         nlen_in = p_nlen; count_in = p_count; stop_in = 1'b0;
         if (p_phase == PHASE_HEADER) begin
            if (h == 5'd0) begin
               meth_in = '0; crc_in = '0; plain_in = '0; recsz_in = '0; nlen_in = '0;
               if (p_pos == '0 && archive_length < 48'(HEADER_BYTES + 1)) begin
                  fail = 1'b1; err = ERR_SPAN;
               end else if (32'(p_count) >= 32'(MAX_MEMBERS)) begin
                  fail = 1'b1; err = ERR_COUNT;
               end else if (remain < 48'(HEADER_BYTES)) begin
                  fail = 1'b1; err = ERR_TRUNC;
               end
            end
            if (!fail) begin
               if (h < 5'd4) begin
                  if (byte_data != magic_byte(h[1:0])) begin
                     fail = 1'b1; err = ERR_MAGIC;
                  end
               end else if (h == 5'd4) begin
                  if (byte_data != VERSION_BYTE) begin
                     fail = 1'b1; err = ERR_VERSION;
                  end
               end else if (h == 5'd5) begin
                  if (byte_data != METHOD_BINARY && byte_data != METHOD_ASCII &&
                      byte_data != METHOD_STORED) begin
                     fail = 1'b1; err = ERR_METHOD;
                  end
                  meth_in = byte_data;
               end else if (h < 5'd10) begin
                  crc_in[8*(h-5'd6) +: 8] = byte_data;
               end else if (h < 5'd14) begin
                  plain_in[8*(h-5'd10) +: 8] = byte_data;
               end else if (h < 5'd18) begin
                  recsz_in[8*(h-5'd14) +: 8] = byte_data;
                  if (h == 5'd17) begin
                     if (recsz_full < 32'(HEADER_BYTES + 1) ||
                         {16'd0, recsz_full} > remain) begin
                        fail = 1'b1; err = ERR_RECORD;
                     end else if (p_plain > plain_limit) begin
                        fail = 1'b1; err = ERR_PLAIN;
                     end
                  end
               end else if (h == 5'd18) begin
                  if (byte_data < 8'd1 || byte_data > 8'(NAME_BUFFER_BYTES)) begin
                     fail = 1'b1; err = ERR_NAME_LEN;
                  end
                  nlen_in = byte_data[3:0];
               end else begin
                  if ((h - 5'd19) < {1'b0, p_nlen} &&
                      (byte_data < PRINT_LOW || byte_data > PRINT_HIGH)) begin
                     fail = 1'b1; err = ERR_NAME_BYTE;
                  end
               end
            end
            if (!fail) begin
               if (h == 5'(HEADER_BYTES - 1)) begin
                  if (p_meth == METHOD_STORED) begin
                     if (packed_sz != p_plain) begin
                        fail = 1'b1; err = ERR_STORED;
                     end else begin
                        acc = 1'b1;
                     end
                  end else if (packed_sz < 32'd3) begin
                     fail = 1'b1; err = ERR_PAYLOAD;
                  end
                  phase_in = PHASE_PAYLOAD;
                  hidx_in = '0;
               end else begin
                  hidx_in = h + 5'd1;
               end
            end
         end else begin
            if (p_meth != METHOD_STORED) begin
               if (pay_off == '0 && byte_data != p_meth) begin
                  fail = 1'b1; err = ERR_MODE;
               end else if (pay_off == 48'd1) begin
                  if (byte_data < DICT_LOW || byte_data > DICT_HIGH) begin
                     fail = 1'b1; err = ERR_DICT;
                  end else begin
                     acc = 1'b1;
                  end
               end
            end
            if (!fail && p_pos == last_pos) begin
               rec_in = next_rec;
               phase_in = PHASE_HEADER;
               hidx_in = '0;
               if (next_rec == archive_length) done = 1'b1;
            end
         end

         if (fail) begin
            stop_in = 1'b1;
            res_valid = 1'b1;
            res_word.kind = KIND_REJECT;
            res_word.err = err;
            res_word.index = p_count;
            res_word.offset = p_rec;
         end else if (done) begin
            stop_in = 1'b1;
            res_valid = 1'b1;
            res_word.kind = KIND_ACCEPT;
            res_word.err = ERR_NONE;
            res_word.index = acc ? p_count + 17'd1 : p_count;
            res_word.offset = next_rec;
         end else if (acc) begin
            res_valid = 1'b1;
            res_word.kind = KIND_MEMBER;
            res_word.err = ERR_NONE;
            res_word.index = p_count;
            res_word.method = meth_in;
            res_word.plain = p_plain;
            res_word.packed_sz = packed_sz;
            res_word.crc = p_crc;
            res_word.name_len = p_nlen;
            res_word.offset = p_rec;
         end
         if (acc && !fail) count_in = p_count + 17'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0; rec_ff <= '0; hidx_ff <= '0; phase_ff <= PHASE_HEADER;
         meth_ff <= '0; crc_ff <= '0; plain_ff <= '0; recsz_ff <= '0;
         nlen_ff <= '0; count_ff <= '0; stop_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in; rec_ff <= rec_in; hidx_ff <= hidx_in; phase_ff <= phase_in;
         meth_ff <= meth_in; crc_ff <= crc_in; plain_ff <= plain_in;
         recsz_ff <= recsz_in; nlen_ff <= nlen_in; count_ff <= count_in;
         stop_ff <= stop_in;
      end
   end

endmodule

>>> hdl/arcc_queue.sv
// Short result queue between the parser front and the output side.
// Depends on arcc_pkg.
`timescale 1ns / 1ps
module arcc_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  arcc_pkg::result_type  push_word,
   output logic                  full,
   output logic                  empty,
   input  logic                  pop,
   output arcc_pkg::result_type  head_word
);
   import arcc_pkg::*;

   result_type  mem_ff [4];
   logic [1:0]  wr_ff, wr_in;
   logic [1:0]  rd_ff, rd_in;
   logic [2:0]  cnt_ff, cnt_in;

   assign full = (cnt_ff == 3'd4);
   assign empty = (cnt_ff == 3'd0);
   assign head_word = mem_ff[rd_ff];

   always_comb begin
      wr_in = push ? wr_ff + 2'd1 : wr_ff;
      rd_in = pop ? rd_ff + 2'd1 : rd_ff;
      cnt_in = cnt_ff + {2'd0, push} - {2'd0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_word;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0; rd_ff <= '0; cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in; rd_ff <= rd_in; cnt_ff <= cnt_in;
      end
   end

endmodule
